// ===== design/crbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked byte ring FIFO package
// Shared operation codes, register map and defaults.
// ----------------------------------------------------------------------------
package crbf_pkg;

  localparam int unsigned CAPACITY_DEF   = 4096;
  localparam int unsigned LANES_DEF      = 8;
  localparam int unsigned MAX_CHUNK_W    = 13;
  localparam int unsigned MAX_CHUNK_RST  = 8;
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned REG_MAX_CHUNK  = 0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic accept;
    logic eval;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic ok;
    logic copy_wr;
    logic copy_rd;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/crbf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked byte ring FIFO controller
// Sequences evaluation, byte-serial copy and result hand-off for one item.
// ----------------------------------------------------------------------------
module crbf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  crbf_pkg::stat_t stat_i,
  output crbf_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COPY,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    stall_d  = stall_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
          stall_d      = 1'b1;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.ok && (stat_i.copy_wr || stat_i.copy_rd)) begin
          state_d = ST_COPY;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_COPY: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = stat_i.copy_rd ? ST_DRAIN : ST_FINISH;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
          stall_d        = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ===== design/crbf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked byte ring FIFO datapath
// Byte store, ring offsets, space check, lane registers and output register.
// ----------------------------------------------------------------------------
module crbf_datapath #(
  parameter int unsigned CAPACITY = crbf_pkg::CAPACITY_DEF,
  parameter int unsigned LANES    = crbf_pkg::LANES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  crbf_pkg::cmd_t                   cmd_i,
  output crbf_pkg::stat_t                  stat_o,
  input  logic [1:0]                       op_i,
  input  logic [crbf_pkg::LEN_W-1:0]       length_i,
  input  logic [crbf_pkg::DATA_W-1:0]      write_data_i,
  input  logic                             no_copy_i,
  input  logic                             cfg_we_i,
  input  logic [crbf_pkg::MAX_CHUNK_W-1:0] cfg_wdata_i,
  output logic [crbf_pkg::MAX_CHUNK_W-1:0] max_chunk_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [crbf_pkg::LEN_W-1:0]       moved_length_o,
  output logic [crbf_pkg::DATA_W-1:0]      read_data_o
);

  localparam int unsigned OFFW  = $clog2(CAPACITY);
  localparam int unsigned SUMW  = ((OFFW > crbf_pkg::MAX_CHUNK_W) ? OFFW
                                   : crbf_pkg::MAX_CHUNK_W) + 1;
  localparam int unsigned IDXW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned LDW   = LANES * 8;
  localparam logic [OFFW:0]          CAP_R = (OFFW + 1)'(CAPACITY);
  localparam logic [SUMW-1:0]        CAP_S = SUMW'(CAPACITY);
  localparam logic [crbf_pkg::LEN_W-1:0] LANES_L = crbf_pkg::LEN_W'(LANES);

  logic [7:0]                       mem [CAPACITY];
  logic [7:0]                       mem_rdata_q;
  logic [OFFW-1:0]                  mem_addr;

  logic [1:0]                       op_q;
  logic [crbf_pkg::LEN_W-1:0]       len_q;
  logic [LDW-1:0]                   wdata_q;
  logic                             no_copy_q;
  logic [OFFW-1:0]                  rd_off_q, rd_off_d;
  logic [OFFW-1:0]                  wr_off_q, wr_off_d;
  logic [OFFW-1:0]                  pos_q;
  logic                             ok_q;
  logic [IDXW-1:0]                  idx_q;
  logic                             cap_q;
  logic [IDXW-1:0]                  cap_lane_q;
  logic [LDW-1:0]                   rdata_q;
  logic [crbf_pkg::MAX_CHUNK_W-1:0] max_chunk_q;
  logic                             out_valid_q;
  logic [crbf_pkg::LEN_W-1:0]       moved_q;
  logic [crbf_pkg::DATA_W-1:0]      read_data_q;

  logic                             is_wr, is_rd;
  logic [OFFW-1:0]                  mov_off, oth_off, pos;
  logic                             wrap;
  logic [OFFW:0]                    room;
  logic                             ok;

  assign is_wr = (op_q == crbf_pkg::OP_WRITE);
  assign is_rd = (op_q == crbf_pkg::OP_READ);

  always_comb begin
    mov_off = is_rd ? rd_off_q : wr_off_q;
    oth_off = is_rd ? wr_off_q : rd_off_q;
    wrap    = (SUMW'(mov_off) + SUMW'(max_chunk_q)) >= CAP_S;
    pos     = wrap ? '0 : mov_off;
    if ((is_wr && (pos >= oth_off)) || (is_rd && (pos > oth_off))) begin
      room = CAP_R - (OFFW + 1)'(pos);
    end else begin
      room = (OFFW + 1)'(oth_off) - (OFFW + 1)'(pos);
    end
    ok = (is_wr || is_rd) && (len_q <= LANES_L) && (room > (OFFW + 1)'(len_q));
  end

  always_comb begin
    rd_off_d = rd_off_q;
    wr_off_d = wr_off_q;
    if (cmd_i.eval) begin
      if (op_q == crbf_pkg::OP_CLEAR) begin
        rd_off_d = '0;
        wr_off_d = '0;
      end else if (ok && is_wr) begin
        wr_off_d = pos + OFFW'(len_q);
      end else if (ok && is_rd) begin
        rd_off_d = pos + OFFW'(len_q);
      end
    end
  end

  assign mem_addr = pos_q + OFFW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && is_wr) begin
      mem[mem_addr] <= wdata_q[idx_q*8 +: 8];
    end
    mem_rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_off_q    <= '0;
      wr_off_q    <= '0;
      max_chunk_q <= crbf_pkg::MAX_CHUNK_W'(crbf_pkg::MAX_CHUNK_RST);
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_off_q <= rd_off_d;
      wr_off_q <= wr_off_d;
      if (cfg_we_i) begin
        max_chunk_q <= cfg_wdata_i;
      end
      cap_q <= cmd_i.step && is_rd;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= op_i;
      len_q     <= length_i;
      wdata_q   <= write_data_i[LDW-1:0];
      no_copy_q <= no_copy_i;
      rdata_q   <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.step) begin
        idx_q <= idx_q + IDXW'(1);
      end
      if (cap_q) begin
        rdata_q[cap_lane_q*8 +: 8] <= mem_rdata_q;
      end
    end
    if (cmd_i.eval) begin
      pos_q <= pos;
      ok_q  <= ok;
    end
    cap_lane_q <= idx_q;
    if (cmd_i.load_out) begin
      moved_q     <= ok_q ? len_q : '0;
      read_data_q <= (ok_q && is_rd && !no_copy_q) ? crbf_pkg::DATA_W'(rdata_q) : '0;
    end
  end

  always_comb begin
    stat_o          = '0;
    stat_o.is_clear = (op_q == crbf_pkg::OP_CLEAR);
    stat_o.ok       = ok;
    stat_o.copy_wr  = is_wr && !no_copy_q && (len_q != '0);
    stat_o.copy_rd  = is_rd && !no_copy_q && (len_q != '0);
    stat_o.last     = (crbf_pkg::LEN_W'(idx_q) == (len_q - crbf_pkg::LEN_W'(1)));
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

  assign max_chunk_o    = max_chunk_q;
  assign out_valid_o    = out_valid_q;
  assign moved_length_o = moved_q;
  assign read_data_o    = read_data_q;

endmodule

// ===== design/chunked_byte_ring_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked byte ring FIFO
// Ring buffer of bytes that writes or reads whole chunks per item, or clears.
// ----------------------------------------------------------------------------
// One item is handled at a time, and the next item can be taken in the cycle
// after a result is loaded. Refused items, clears and no-copy items go from
// acceptance through an evaluation state to a finish state that loads their
// result. A chunk write adds a copy state, and a chunk read a copy state and
// a drain state, since the single-port byte store moves one byte per cycle and
// its read data is registered. A finished result waits in an output register,
// so the next item is taken while it is still stalled, but that item's result
// is only loaded once the waiting one has been taken. The byte store has no
// reset and needs no clearing pass. max_chunk is written through the APB port
// at address 0 by the user, only while the block is idle; it is not enforced.
module chunked_byte_ring_fifo #(
  parameter int unsigned CAPACITY = crbf_pkg::CAPACITY_DEF,
  parameter int unsigned LANES    = crbf_pkg::LANES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [crbf_pkg::LEN_W-1:0]    length_i,
  input  logic [crbf_pkg::DATA_W-1:0]   write_data_i,
  input  logic                          no_copy_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [crbf_pkg::LEN_W-1:0]    moved_length_o,
  output logic [crbf_pkg::DATA_W-1:0]   read_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crbf_pkg::PADDR_W-1:0]  paddr,
  input  logic [crbf_pkg::PDATA_W-1:0]  pwdata,
  output logic [crbf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  crbf_pkg::cmd_t                   cmd;
  crbf_pkg::stat_t                  stat;
  logic                             reg_hit;
  logic                             cfg_we;
  logic [crbf_pkg::MAX_CHUNK_W-1:0] max_chunk;

  assign reg_hit = (paddr[crbf_pkg::PADDR_W-1:2]
                    == (crbf_pkg::PADDR_W - 2)'(crbf_pkg::REG_MAX_CHUNK));
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? crbf_pkg::PDATA_W'(max_chunk) : '0;

  crbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crbf_datapath #(
    .CAPACITY (CAPACITY),
    .LANES    (LANES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .length_i       (length_i),
    .write_data_i   (write_data_i),
    .no_copy_i      (no_copy_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[crbf_pkg::MAX_CHUNK_W-1:0]),
    .max_chunk_o    (max_chunk),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .moved_length_o (moved_length_o),
    .read_data_o    (read_data_o)
  );

endmodule

// ===== design/crbf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked byte ring FIFO checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module crbf_checker #(
  parameter int unsigned LANES = crbf_pkg::LANES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [crbf_pkg::LEN_W-1:0]  moved_length_o,
  input logic [crbf_pkg::DATA_W-1:0] read_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result item was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(moved_length_o) && $stable(read_data_o))
    else $error("Stalled result item changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again while an item is in work.");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> moved_length_o <= crbf_pkg::LEN_W'(LANES))
    else $error("Moved length exceeds the lane count.");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (moved_length_o == '0) |-> read_data_o == '0)
    else $error("Refused or empty item carries read data.");

endmodule

bind chunked_byte_ring_fifo crbf_checker #(
  .LANES (LANES)
) u_crbf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .moved_length_o (moved_length_o),
  .read_data_o    (read_data_o)
);
